>>> src/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHMM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shmm assertion failed");

// next-cycle implication
`define SHMM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shmm assertion failed");

`endif

>>> src/shmm_pkg.sv
package shmm_pkg;

   localparam int unsigned DUMP_WORDS = 4;

   localparam logic       IN_CHAR = 1'b0;
   localparam logic       IN_READ = 1'b1;

   localparam logic [1:0] OUT_TX    = 2'd0;
   localparam logic [1:0] OUT_READ  = 2'd1;
   localparam logic [1:0] OUT_WRITE = 2'd2;
   localparam logic [1:0] OUT_JUMP  = 2'd3;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_O     = 8'h6f;

   typedef struct packed {
      logic        kind;
      logic [7:0]  rx_char;
      logic [31:0] read_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  tx_char;
      logic [31:0] bus_addr;
      logic [31:0] bus_wdata;
      logic        last;
   } rsp_type;

   // output sequence that one accepted word produces
   typedef enum logic [7:0] {
      SEQ_ECHO     = 8'b0000_0001,
      SEQ_DUMP     = 8'b0000_0010,
      SEQ_JUMP     = 8'b0000_0100,
      SEQ_WRITE    = 8'b0000_1000,
      SEQ_NOWRITE  = 8'b0001_0000,
      SEQ_ERROR    = 8'b0010_0000,
      SEQ_WORD     = 8'b0100_0000,
      SEQ_WORD_END = 8'b1000_0000
   } seq_type;

   function automatic logic [3:0] seq_last_idx(input seq_type s);
      logic [3:0] r;
      case (s)
         SEQ_ECHO:     r = 4'd0;
         SEQ_DUMP:     r = 4'd11;
         SEQ_JUMP:     r = 4'd4;
         SEQ_WRITE:    r = 4'd4;
         SEQ_NOWRITE:  r = 4'd3;
         SEQ_ERROR:    r = 4'd10;
         SEQ_WORD:     r = 4'd9;
         SEQ_WORD_END: r = 4'd12;
         default:      r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d >= 4'd10) begin
         r = CH_LA + {4'd0, d} - 8'd10;
      end else begin
         r = CH_0 + {4'd0, d};
      end
      return r;
   endfunction

endpackage

>>> src/serial_hex_memory_monitor_core.sv
// channel | dir | ports                          | word
// req     | in  | req_valid, req_ready, req_data | char or read data
// rsp     | out | rsp_valid, rsp_ready, rsp_data | tx char / bus request
//
// Each accepted word is decoded and then emits 0 to 13 results, one per
// cycle from the result register while rsp_ready does not stall it.
// A new word is taken in the cycle its last result is loaded, so words
// with one result stream back to back. Synchronous active-high reset clears
// the monitor state and drops rsp_valid. A stalled rsp_ready holds the
// result register and, through it, the input.
module serial_hex_memory_monitor_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  shmm_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output shmm_pkg::rsp_type   rsp_data
);

   // monitor state
   logic        awaiting_ff, awaiting_in;
   logic [7:0]  linepos_ff, linepos_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [31:0] addr_acc_ff, addr_acc_in;
   logic [31:0] val_acc_ff, val_acc_in;
   logic        space_ff, space_in;
   logic [1:0]  dump_idx_ff, dump_idx_in;

   // emit plan
   logic              busy_ff, busy_in;
   logic [3:0]        idx_ff, idx_in;
   shmm_pkg::seq_type seq_ff, seq_in;
   logic [31:0]       hex_ff, hex_in;
   logic [31:0]       addr_ff, addr_in;
   logic [31:0]       wdata_ff, wdata_in;
   logic              plan_new;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   shmm_pkg::rsp_type rsp_ff, rsp_in;

   logic              req_accept;
   logic              gen_go;
   logic              gen_last;
   shmm_pkg::rsp_type gen;
   logic [2:0]        nib_sel;
   logic [31:0]       hex_shift;
   logic [7:0]        c;
   logic [7:0]        cmd_eff;
   logic              is_af, is_09;
   logic [3:0]        digit;
   logic [1:0]        next_dump;

   assign gen_last   = (idx_ff == shmm_pkg::seq_last_idx(seq_ff));
   assign gen_go     = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !busy_ff || (gen_go && gen_last);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign c       = req_data.rx_char;
   assign cmd_eff = (linepos_ff == 8'd0) ? 8'd0 : cmd_ff;
   assign is_af   = c inside {[shmm_pkg::CH_LA:shmm_pkg::CH_LF_HEX]};
   assign is_09   = c inside {[shmm_pkg::CH_0:shmm_pkg::CH_9]};
   assign digit   = is_af ? 4'(c[3:0] + 4'd9) : c[3:0];
   assign next_dump = dump_idx_ff + 2'd1;

   // decode of an accepted word
   always_comb begin
      awaiting_in = awaiting_ff;
      linepos_in  = linepos_ff;
      cmd_in      = cmd_ff;
      addr_acc_in = addr_acc_ff;
      val_acc_in  = val_acc_ff;
      space_in    = space_ff;
      dump_idx_in = dump_idx_ff;
      plan_new    = 1'b0;
      seq_in      = seq_ff;
      hex_in      = hex_ff;
      addr_in     = addr_ff;
      wdata_in    = wdata_ff;
      if (req_accept) begin
         if (req_data.kind == shmm_pkg::IN_CHAR && !awaiting_ff) begin
            plan_new = 1'b1;
            if (c == shmm_pkg::CH_CR) begin
               linepos_in  = 8'd0;
               cmd_in      = 8'd0;
               addr_acc_in = 32'd0;
               val_acc_in  = 32'd0;
               space_in    = 1'b0;
               case (cmd_eff)
                  shmm_pkg::CH_D: begin
                     // line kept until the dump ends
                     seq_in      = shmm_pkg::SEQ_DUMP;
                     hex_in      = addr_acc_ff;
                     addr_in     = addr_acc_ff;
                     dump_idx_in = 2'd0;
                     awaiting_in = 1'b1;
                     linepos_in  = linepos_ff;
                     cmd_in      = cmd_ff;
                     addr_acc_in = addr_acc_ff;
                     val_acc_in  = val_acc_ff;
                     space_in    = space_ff;
                  end
                  shmm_pkg::CH_G: begin
                     seq_in  = shmm_pkg::SEQ_JUMP;
                     addr_in = addr_acc_ff;
                  end
                  shmm_pkg::CH_W: begin
                     seq_in   = space_ff ? shmm_pkg::SEQ_WRITE : shmm_pkg::SEQ_NOWRITE;
                     addr_in  = addr_acc_ff;
                     wdata_in = val_acc_ff;
                  end
                  default: begin
                     seq_in = shmm_pkg::SEQ_ERROR;
                  end
               endcase
            end else begin
               seq_in = shmm_pkg::SEQ_ECHO;
               hex_in = {24'd0, c};
               if (linepos_ff == 8'd0) begin
                  cmd_in = c;
               end else if (linepos_ff >= 8'd2) begin
                  if (c == shmm_pkg::CH_SPACE && !space_ff) begin
                     space_in = 1'b1;
                  end else if (is_af || is_09) begin
                     if (cmd_ff == shmm_pkg::CH_W && space_ff) begin
                        val_acc_in = {val_acc_ff[27:0], digit};
                     end else begin
                        addr_acc_in = {addr_acc_ff[27:0], digit};
                     end
                  end
               end
               if (linepos_ff != 8'hff) begin
                  linepos_in = linepos_ff + 8'd1;
               end
            end
         end else if (req_data.kind == shmm_pkg::IN_READ && awaiting_ff) begin
            plan_new = 1'b1;
            hex_in   = req_data.read_data;
            if ({1'b0, dump_idx_ff} + 3'd1 < 3'(shmm_pkg::DUMP_WORDS)) begin
               seq_in      = shmm_pkg::SEQ_WORD;
               dump_idx_in = next_dump;
               addr_in     = addr_acc_ff + {28'd0, next_dump, 2'b00};
            end else begin
               seq_in      = shmm_pkg::SEQ_WORD_END;
               awaiting_in = 1'b0;
               dump_idx_in = 2'd0;
               linepos_in  = 8'd0;
               cmd_in      = 8'd0;
               addr_acc_in = 32'd0;
               val_acc_in  = 32'd0;
               space_in    = 1'b0;
            end
         end
      end
   end

   // result generator
   always_comb begin
      nib_sel = 3'd0;
      if (seq_ff == shmm_pkg::SEQ_DUMP) begin
         nib_sel = 3'(4'd9 - idx_ff);
      end else begin
         nib_sel = 3'(4'd8 - idx_ff);
      end
   end

   assign hex_shift = hex_ff >> {nib_sel, 2'b00};

   always_comb begin
      gen           = '0;
      gen.out_kind  = shmm_pkg::OUT_TX;
      gen.last      = gen_last;
      case (seq_ff)
         shmm_pkg::SEQ_ECHO: begin
            gen.tx_char = hex_ff[7:0];
         end
         shmm_pkg::SEQ_DUMP: begin
            case (idx_ff)
               4'd0:    gen.tx_char = shmm_pkg::CH_CR;
               4'd1:    gen.tx_char = shmm_pkg::CH_LF;
               4'd10:   gen.tx_char = shmm_pkg::CH_SPACE;
               4'd11: begin
                  gen.out_kind = shmm_pkg::OUT_READ;
                  gen.bus_addr = addr_ff;
               end
               default: gen.tx_char = shmm_pkg::hex_char(hex_shift[3:0]);
            endcase
         end
         shmm_pkg::SEQ_JUMP, shmm_pkg::SEQ_WRITE: begin
            case (idx_ff)
               4'd0:    gen.tx_char = shmm_pkg::CH_CR;
               4'd1:    gen.tx_char = shmm_pkg::CH_LF;
               4'd2: begin
                  gen.bus_addr = addr_ff;
                  if (seq_ff == shmm_pkg::SEQ_JUMP) begin
                     gen.out_kind = shmm_pkg::OUT_JUMP;
                  end else begin
                     gen.out_kind  = shmm_pkg::OUT_WRITE;
                     gen.bus_wdata = wdata_ff;
                  end
               end
               4'd3:    gen.tx_char = shmm_pkg::CH_GT;
               default: gen.tx_char = shmm_pkg::CH_SPACE;
            endcase
         end
         shmm_pkg::SEQ_NOWRITE: begin
            case (idx_ff)
               4'd0:    gen.tx_char = shmm_pkg::CH_CR;
               4'd1:    gen.tx_char = shmm_pkg::CH_LF;
               4'd2:    gen.tx_char = shmm_pkg::CH_GT;
               default: gen.tx_char = shmm_pkg::CH_SPACE;
            endcase
         end
         shmm_pkg::SEQ_ERROR: begin
            case (idx_ff)
               4'd0, 4'd7: gen.tx_char = shmm_pkg::CH_CR;
               4'd1, 4'd8: gen.tx_char = shmm_pkg::CH_LF;
               4'd2:       gen.tx_char = shmm_pkg::CH_E;
               4'd3, 4'd4, 4'd6: gen.tx_char = shmm_pkg::CH_R;
               4'd5:       gen.tx_char = shmm_pkg::CH_O;
               4'd9:       gen.tx_char = shmm_pkg::CH_GT;
               default:    gen.tx_char = shmm_pkg::CH_SPACE;
            endcase
         end
         shmm_pkg::SEQ_WORD, shmm_pkg::SEQ_WORD_END: begin
            case (idx_ff)
               4'd0: gen.tx_char = shmm_pkg::CH_SPACE;
               4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: begin
                  gen.tx_char = shmm_pkg::hex_char(hex_shift[3:0]);
               end
               4'd9: begin
                  if (seq_ff == shmm_pkg::SEQ_WORD) begin
                     gen.out_kind = shmm_pkg::OUT_READ;
                     gen.bus_addr = addr_ff;
                  end else begin
                     gen.tx_char = shmm_pkg::CH_CR;
                  end
               end
               4'd10:   gen.tx_char = shmm_pkg::CH_LF;
               4'd11:   gen.tx_char = shmm_pkg::CH_GT;
               default: gen.tx_char = shmm_pkg::CH_SPACE;
            endcase
         end
         default: begin
            gen.tx_char = 8'd0;
         end
      endcase
   end

   // emitter control
   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (gen_go) begin
         rsp_in       = gen;
         rsp_valid_in = 1'b1;
         idx_in       = idx_ff + 4'd1;
         if (gen_last) begin
            busy_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (plan_new) begin
         busy_in = 1'b1;
         idx_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         linepos_ff   <= 8'd0;
         cmd_ff       <= 8'd0;
         addr_acc_ff  <= 32'd0;
         val_acc_ff   <= 32'd0;
         space_ff     <= 1'b0;
         dump_idx_ff  <= 2'd0;
         busy_ff      <= 1'b0;
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         awaiting_ff  <= awaiting_in;
         linepos_ff   <= linepos_in;
         cmd_ff       <= cmd_in;
         addr_acc_ff  <= addr_acc_in;
         val_acc_ff   <= val_acc_in;
         space_ff     <= space_in;
         dump_idx_ff  <= dump_idx_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff   <= seq_in;
      hex_ff   <= hex_in;
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      rsp_ff   <= rsp_in;
   end

endmodule

>>> src/shmm_checker.sv
`include "assert_macros.svh"

module shmm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input shmm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input shmm_pkg::rsp_type rsp_data
);

   logic tx_word;

   assign tx_word = rsp_valid && (rsp_data.out_kind == shmm_pkg::OUT_TX);

   `SHMM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `SHMM_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `SHMM_ASSERT_IMP(a_tx_no_bus, clock, reset, tx_word, rsp_data.bus_addr == 32'd0 && rsp_data.bus_wdata == 32'd0)
   `SHMM_ASSERT_IMP(a_bus_no_char, clock, reset, rsp_valid && !tx_word, rsp_data.tx_char == 8'd0 && (rsp_data.out_kind == shmm_pkg::OUT_WRITE || rsp_data.bus_wdata == 32'd0))

endmodule

bind serial_hex_memory_monitor_core shmm_checker u_shmm_checker (.*);
